// ----- sv/smla_pkg.sv -----
// shared types and constants of the scaled moving average limit unit
package smla_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_RAW_ORIGIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_ORIGIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_ENABLE  = 3'd6;

    localparam logic [11:0]        RST_RAW_ORIGIN    = 12'd2170;
    localparam logic signed [15:0] RST_OUT_ORIGIN    = -16'sd12616;
    localparam logic signed [23:0] RST_GAIN          = 24'sd915571;
    localparam logic [6:0]         RST_WINDOW_LENGTH = 7'd50;
    localparam logic signed [15:0] RST_LOW_LIMIT     = -16'sd9830;
    localparam logic signed [15:0] RST_HIGH_LIMIT    = 16'sd13517;
    localparam logic               RST_LIMIT_ENABLE  = 1'b1;

    localparam logic signed [21:0] SAMPLE_MAX = 22'sd32767;
    localparam logic signed [21:0] SAMPLE_MIN = -22'sd32768;

    typedef struct packed {
        logic [11:0]        raw_origin;
        logic signed [15:0] out_origin;
        logic signed [23:0] gain;
        logic [6:0]         window_length;
        logic signed [15:0] low_limit;
        logic signed [15:0] high_limit;
        logic               limit_enable;
    } smla_cfg_t;

endpackage

// ----- sv/scaled_moving_average_limit_unit.sv -----
// top level of the scaled moving average limit unit
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   input    | in_valid / in_stall     | raw_sample
//   output   | out_valid / out_stall   | mean_value, fault_latched
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// an item passes the back end through the states idle, update, divide and done;
// the divide state runs the bit-serial divider of sum over fill count.
// the front end scales the next item and queues it while the back end works.
// reset clears the sum, fill count, ring pointer and fault; the sample ring
// needs no clearing since an entry is read only after it was written.
// a stalled output holds its item; the back end waits in its last step.
module scaled_moving_average_limit_unit
    import smla_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [11:0]            raw_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [15:0]     mean_value,
    output logic                   fault_latched,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    smla_cfg_t          cfg_reg;
    smla_cfg_t          cfg_next;
    logic               cfg_wr;
    logic               restart;
    logic               q_wr;
    logic signed [15:0] q_wr_data;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic signed [15:0] q_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == REG_WINDOW_LENGTH);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_RAW_ORIGIN:    cfg_next.raw_origin    = cfg_data[11:0];
                REG_OUT_ORIGIN:    cfg_next.out_origin    = cfg_data[15:0];
                REG_GAIN:          cfg_next.gain          = cfg_data[23:0];
                REG_WINDOW_LENGTH: cfg_next.window_length = cfg_data[6:0];
                REG_LOW_LIMIT:     cfg_next.low_limit     = cfg_data[15:0];
                REG_HIGH_LIMIT:    cfg_next.high_limit    = cfg_data[15:0];
                REG_LIMIT_ENABLE:  cfg_next.limit_enable  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_origin    <= RST_RAW_ORIGIN;
            cfg_reg.out_origin    <= RST_OUT_ORIGIN;
            cfg_reg.gain          <= RST_GAIN;
            cfg_reg.window_length <= RST_WINDOW_LENGTH;
            cfg_reg.low_limit     <= RST_LOW_LIMIT;
            cfg_reg.high_limit    <= RST_HIGH_LIMIT;
            cfg_reg.limit_enable  <= RST_LIMIT_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    smla_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_wr_data  (q_wr_data)
    );

    smla_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd        (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_rd_data)
    );

    smla_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .restart       (restart),
        .q_valid       (q_valid),
        .q_data        (q_rd_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_value    (mean_value),
        .fault_latched (fault_latched)
    );

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr && q_full))
        else $error("queue written while full");

    // the queue is never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && !q_valid))
        else $error("queue read while empty");

    // fault is sticky until reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_latched |=> fault_latched)
        else $error("fault flag cleared without reset");

endmodule

// ----- sv/smla_front.sv -----
// front end: takes raw samples and scales them to signed Q3.12
module smla_front
    import smla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  smla_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        raw_sample,
    input  logic               q_full,
    output logic               q_wr,
    output logic signed [15:0] q_wr_data
);

    logic               p_valid_reg;
    logic               p_valid_next;
    logic signed [36:0] prod_reg;
    logic signed [36:0] prod_next;
    logic signed [12:0] diff;
    logic signed [20:0] shifted;
    logic signed [21:0] sum_wide;
    logic               take;

    assign diff      = $signed({1'b0, raw_sample}) - $signed({1'b0, cfg.raw_origin});
    assign prod_next = 37'($signed(cfg.gain)) * 37'(diff);

    assign q_wr     = p_valid_reg && !q_full;
    assign in_stall = p_valid_reg && !q_wr;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (take)
        begin
            p_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            p_valid_next = 1'b0;
        end
    end

    // floor shift by 16, then offset and clamp to 16 bits
    always_comb
    begin
        shifted  = prod_reg[36:16];
        sum_wide = 22'($signed(cfg.out_origin)) + 22'(shifted);
        if (sum_wide > SAMPLE_MAX)
        begin
            q_wr_data = SAMPLE_MAX[15:0];
        end
        else if (sum_wide < SAMPLE_MIN)
        begin
            q_wr_data = SAMPLE_MIN[15:0];
        end
        else
        begin
            q_wr_data = sum_wide[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- sv/smla_fifo.sv -----
// short queue of scaled samples between front and back
module smla_fifo
    import smla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  logic signed [15:0] wr_data,
    output logic               full,
    input  logic               rd,
    output logic               not_empty,
    output logic signed [15:0] rd_data
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [15:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/smla_back.sv -----
// back end: sample ring, running sum, bit-serial divider and limit check
module smla_back
    import smla_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  smla_cfg_t          cfg,
    input  logic               restart,
    input  logic               q_valid,
    input  logic signed [15:0] q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mean_value,
    output logic               fault_latched
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = (FILL_W > 7) ? FILL_W : 7;
    localparam int SUM_W  = 17 + PTR_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic signed [15:0] store_mem [MAX_WINDOW];

    logic [1:0]              state_reg, state_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [DCNT_W-1:0]       dcnt_reg, dcnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    fault_reg, fault_next;

    logic signed [15:0]      s_reg, rd_reg;
    logic [SUM_W-1:0]        mag_reg, mag_next;
    logic [FILL_W-1:0]       rem_reg, rem_next;
    logic [FILL_W-1:0]       div_reg, div_next;
    logic                    neg_reg, neg_next;
    logic signed [15:0]      mean_reg, mean_next;

    logic [CNT_W-1:0]        wl_ext;
    logic [FILL_W-1:0]       w_eff;
    logic                    full;
    logic [PTR_W:0]          ptr_inc;
    logic signed [SUM_W-1:0] sum_upd;
    logic [FILL_W:0]         sh;
    logic [FILL_W:0]         trial;
    logic                    ge;
    logic [SUM_W-1:0]        quo;
    logic signed [15:0]      mean_c;
    logic                    out_free;

    // window length zero acts as one, above the store depth it is clamped
    always_comb
    begin
        wl_ext = CNT_W'(cfg.window_length);
        if (wl_ext == '0)
        begin
            w_eff = FILL_W'(1);
        end
        else if (wl_ext > CNT_W'(MAX_WINDOW))
        begin
            w_eff = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = FILL_W'(wl_ext);
        end
    end

    assign full    = (fill_reg == w_eff);
    assign ptr_inc = {1'b0, ptr_reg} + 1'b1;
    assign sum_upd = sum_reg - (full ? SUM_W'(rd_reg) : '0) + SUM_W'(s_reg);

    // one restoring step per cycle on the magnitude
    assign sh    = {rem_reg, mag_reg[SUM_W-1]};
    assign trial = sh - {1'b0, div_reg};
    assign ge    = !trial[FILL_W];

    assign quo      = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign mean_c   = quo[15:0];
    assign out_free = !out_valid_reg || !out_stall;

    assign q_pop         = (state_reg == ST_IDLE) && q_valid;
    assign out_valid     = out_valid_reg;
    assign mean_value    = mean_reg;
    assign fault_latched = fault_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        fault_next     = fault_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        mean_next      = mean_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                sum_next  = sum_upd;
                fill_next = full ? fill_reg : fill_reg + 1'b1;
                ptr_next  = (ptr_inc == (PTR_W + 1)'(w_eff)) ? '0 : ptr_inc[PTR_W-1:0];
                neg_next  = sum_upd[SUM_W-1];
                mag_next  = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
                rem_next  = '0;
                div_next  = full ? fill_reg : fill_reg + 1'b1;
                dcnt_next = DCNT_W'(SUM_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mag_next  = {mag_reg[SUM_W-2:0], ge};
                rem_next  = ge ? trial[FILL_W-1:0] : sh[FILL_W-1:0];
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = mean_c;
                    if (cfg.limit_enable &&
                        (mean_c < cfg.low_limit || mean_c > cfg.high_limit))
                    begin
                        fault_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new window length starts the average over; the fault stays
        if (restart)
        begin
            sum_next  = '0;
            ptr_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            fault_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s_reg <= q_data;
        end
        if (state_reg == ST_UPD)
        begin
            store_mem[ptr_reg] <= s_reg;
        end
        // oldest entry of the ring, ready by the update cycle
        rd_reg   <= store_mem[ptr_reg];
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
    end

endmodule
